[design/lpht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared constants, codes and types of the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int KEY_BITS   = 32;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int SIZE_W     = SLOT_W + 1;
    localparam int SIZE_RESET = 1001;
    localparam int SIZE_MIN   = 11;
    localparam int ENTRY_W    = KEY_BITS + 1;

    // Operation codes carried on the kind field
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FIND   = 1'b1;

    // Request into the remainder unit
    typedef struct packed {
        logic                start;
        logic [KEY_BITS-1:0] key;
        logic [SIZE_W-1:0]   modulus;
    } t_div_req;

    // Response from the remainder unit
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] rem;
    } t_div_rsp;

endpackage

[design/lpht_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/lpht_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_mod
// Bit-serial restoring remainder unit: key modulo table size, one key bit per
// cycle.
// ----------------------------------------------------------------------------
module lpht_mod
    import lpht_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(KEY_BITS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [KEY_BITS-1:0] r_dvd;
    logic [SIZE_W-1:0]   r_rem;
    logic [SIZE_W-1:0]   r_mod;

    logic [SIZE_W:0]     w_trial;
    logic [SIZE_W:0]     w_mod_ext;
    logic [SIZE_W-1:0]   n_rem;

    // Shift in the next key bit and subtract when it fits
    always_comb begin
        w_trial   = {r_rem, r_dvd[KEY_BITS-1]};
        w_mod_ext = {1'b0, r_mod};
        if (w_trial >= w_mod_ext) begin
            n_rem = SIZE_W'(w_trial - w_mod_ext);
        end else begin
            n_rem = SIZE_W'(w_trial);
        end
    end

    // Control: load on start, count key bits, pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(KEY_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifter and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.key;
            r_rem <= '0;
            r_mod <= i_req.modulus;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[KEY_BITS-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[SLOT_W-1:0];

    // A new request never lands on a running one
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("remainder unit restarted while busy");

    // The partial remainder stays below the modulus
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy || r_done) |-> (r_rem < r_mod))
        else $error("partial remainder out of range");

    // Done follows the last step only
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("done without a finishing step");

endmodule

[design/linear_probe_hash_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open-addressing hash table with linear probing over one slot RAM.
// ----------------------------------------------------------------------------
// Operation: the serial remainder unit computes the home slot, then each probe
//   reads the slot RAM (S_RD) and checks or writes the slot (S_CHK), and S_OUT
//   registers the result beat.
// Throughput: one operation at a time; the input stalls until the result beat
//   is registered and the unit is back in idle, so the serial remainder unit
//   and the probe loop set the pace; a stalled result beat holds the output step.
// Reset: a clearing pass writes all 1024 slots empty with the input stalled;
//   table_size resets to 1001, the entry count to zero.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit
    import lpht_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // operation input
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_kind,
    input  logic [KEY_BITS-1:0] i_key,
    // result output
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_hit,
    output logic                o_full_res,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [SIZE_W-1:0]   o_entry_count,
    // configuration write
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SIZE_W-1:0]   i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK,
        S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_clr, n_clr;
    logic [SIZE_W-1:0]   r_table_size;
    logic [SIZE_W-1:0]   r_n, n_n;
    logic                r_kind, n_kind;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [SLOT_W-1:0]   r_pos, n_pos;
    logic [SIZE_W-1:0]   r_probe, n_probe;
    logic [SIZE_W-1:0]   r_count, n_count;
    logic                r_res_hit, n_res_hit;
    logic                r_res_full, n_res_full;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic                r_out_valid, n_out_valid;
    logic                r_hit, n_hit;
    logic                r_full, n_full;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [SIZE_W-1:0]   r_cnt_out, n_cnt_out;

    logic                w_accept;
    logic [SIZE_W-1:0]   w_live;
    logic [SIZE_W-1:0]   w_probe_inc;
    logic                w_last_probe;
    logic [SLOT_W-1:0]   w_pos_next;
    logic                w_used;
    logic [KEY_BITS-1:0] w_slot_key;
    logic                w_we;
    logic [SLOT_W-1:0]   w_waddr;
    logic [ENTRY_W-1:0]  w_wdata;
    logic [ENTRY_W-1:0]  w_rdata;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    // Slot store: occupied flag over key
    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_pos),
        .o_rdata (w_rdata)
    );

    // Home slot remainder
    lpht_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Clamp the configured size to the usable range
    always_comb begin
        if (r_table_size < SIZE_W'(SIZE_MIN)) begin
            w_live = SIZE_W'(SIZE_MIN);
        end else if (r_table_size > SIZE_W'(MAX_SLOTS)) begin
            w_live = SIZE_W'(MAX_SLOTS);
        end else begin
            w_live = r_table_size;
        end
    end

    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_div_req.start   = w_accept;
    assign w_div_req.key     = i_key;
    assign w_div_req.modulus = w_live;

    // Probe stepping with wrap at the live size
    assign w_used       = w_rdata[ENTRY_W-1];
    assign w_slot_key   = w_rdata[KEY_BITS-1:0];
    assign w_probe_inc  = r_probe + 1'b1;
    assign w_last_probe = (w_probe_inc == r_n);
    assign w_pos_next   = (({1'b0, r_pos} + SIZE_W'(1)) == r_n) ? '0 : r_pos + 1'b1;

    // RAM write: clearing pass or insert into a free slot
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = {1'b1, r_key};
        if (r_state == S_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (r_state == S_CHK && r_kind == KIND_INSERT && !w_used) begin
            w_we = 1'b1;
        end
    end

    // Next-state logic
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_n         = r_n;
        n_kind      = r_kind;
        n_key       = r_key;
        n_pos       = r_pos;
        n_probe     = r_probe;
        n_count     = r_count;
        n_res_hit   = r_res_hit;
        n_res_full  = r_res_full;
        n_res_slot  = r_res_slot;
        n_out_valid = r_out_valid;
        n_hit       = r_hit;
        n_full      = r_full;
        n_slot      = r_slot;
        n_cnt_out   = r_cnt_out;

        // drop the output beat once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == SLOT_W'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_kind  = i_kind;
                    n_key   = i_key;
                    n_n     = w_live;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_pos   = w_div_rsp.rem;
                    n_probe = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                n_res_hit  = 1'b0;
                n_res_full = 1'b0;
                n_res_slot = '0;
                if (!w_used) begin
                    // empty slot ends both insert and find
                    if (r_kind == KIND_INSERT) begin
                        n_res_hit  = 1'b1;
                        n_res_slot = r_pos;
                        n_count    = r_count + 1'b1;
                    end
                    n_state = S_OUT;
                end else if (r_kind == KIND_FIND && w_slot_key == r_key) begin
                    n_res_hit  = 1'b1;
                    n_res_slot = r_pos;
                    n_state    = S_OUT;
                end else if (w_last_probe) begin
                    // every slot visited
                    n_res_full = (r_kind == KIND_INSERT);
                    n_state    = S_OUT;
                end else begin
                    n_probe = w_probe_inc;
                    n_pos   = w_pos_next;
                    n_state = S_RD;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_hit       = r_res_hit;
                    n_full      = r_res_full;
                    n_slot      = r_res_slot;
                    n_cnt_out   = r_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, control and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLR;
            r_clr        <= '0;
            r_table_size <= SIZE_W'(SIZE_RESET);
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_table_size <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_pos      <= n_pos;
        r_probe    <= n_probe;
        r_res_hit  <= n_res_hit;
        r_res_full <= n_res_full;
        r_res_slot <= n_res_slot;
        r_hit      <= n_hit;
        r_full     <= n_full;
        r_slot     <= n_slot;
        r_cnt_out  <= n_cnt_out;
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_full_res    = r_full;
    assign o_slot        = r_slot;
    assign o_entry_count = r_cnt_out;

    // No operation starts during the clearing pass
    a_clr_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> o_in_stall)
        else $error("input taken during clearing pass");

    // Probe position and count stay inside the live table
    a_probe_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_CHK) |->
            (({1'b0, r_pos} < r_n) && (r_probe < r_n)))
        else $error("probe outside live table");

    // The entry count never exceeds the slot count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SIZE_W'(MAX_SLOTS))
        else $error("entry count overflow");

    // A refused insert never reports a hit
    a_full_nohit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !(r_res_full && r_res_hit))
        else $error("result both full and hit");

endmodule
